// ===== src/dba_pkg.sv =====
// Shared types and constants for the button debounce and auto-repeat block.
// Used by every module of the block; depends on nothing.
package dba_pkg;

    localparam int NUM_BUTTONS  = 8;
    localparam int PIN_COUNT    = 8;
    localparam int MASK_BUTTONS = (NUM_BUTTONS < PIN_COUNT) ? NUM_BUTTONS : PIN_COUNT;

    localparam int IDX_W      = 3;
    localparam int SAMPLE_W   = 8;
    localparam int DEBOUNCE_W = 7;
    localparam int DELAY_W    = 16;

    localparam int CFG_INDEX_W = 8;
    localparam int CFG_DATA_W  = 16;

    localparam int S_TDATA_W = 16;
    localparam int M_TDATA_W = 16;

    localparam logic [CFG_INDEX_W-1:0] REG_ACTIVE_LEVEL     = 8'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_DEBOUNCE_SAMPLES = 8'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_HOLD_DELAY       = 8'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_REPEAT_DELAY     = 8'd3;

    localparam logic [DEBOUNCE_W-1:0] DEBOUNCE_RESET = 7'd10;
    localparam logic [DELAY_W-1:0]    HOLD_RESET     = 16'd500;
    localparam logic [DELAY_W-1:0]    REPEAT_RESET   = 16'd100;

    typedef enum logic {
        OP_TICK = 1'b0,
        OP_TAKE = 1'b1
    } op_t;

    typedef struct packed {
        logic                  active_level;
        logic [DEBOUNCE_W-1:0] debounce_samples;
        logic [DELAY_W-1:0]    hold_delay;
        logic [DELAY_W-1:0]    repeat_delay;
    } cfg_t;

    typedef struct packed {
        logic tick;
        logic take;
    } btn_cmd_t;

endpackage

// ===== src/button_debounce_autorepeat.sv =====
// Top level of the button debounce and auto-repeat block.
// Depends on dba_pkg, dba_cfg_regs and dba_button.
//
// One beat in gives exactly one beat out. A tick beat (tuser 0) samples one pin level per
// button and advances every button's debounce, hold and repeat counters; a take beat
// (tuser 1) returns the typed flag of the button named in button_index and clears it.
// Every result carries the debounced pressed mask after the beat, and typed_flag is 0 on
// a tick. A beat is taken into an input register, processed combinationally by the per-button
// update logic into a result register, and the block accepts a new beat every cycle while
// the result side keeps up. The configuration channel is always ready; write it only
// while the block is idle.
module button_debounce_autorepeat (
    input  logic                              aclk,
    input  logic                              aresetn,
    // Configuration write channel.
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [dba_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [dba_pkg::CFG_DATA_W-1:0]    cfg_data,
    // Input stream.
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [dba_pkg::S_TDATA_W-1:0]     s_tdata,   // pin_levels[7:0], button_index[10:8]
    input  logic                              s_tuser,   // operation
    // Result stream.
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [dba_pkg::M_TDATA_W-1:0]     m_tdata    // pressed_bits[7:0], typed_flag[8]
);
    import dba_pkg::*;

    cfg_t cfg;

    logic                 in_valid_reg, in_valid_next;
    op_t                  in_op_reg;
    logic [PIN_COUNT-1:0] in_pins_reg;
    logic [IDX_W-1:0]     in_idx_reg;

    logic                   out_valid_reg, out_valid_next;
    logic [MASK_BUTTONS-1:0] out_pressed_reg;
    logic                   out_typed_reg;

    logic                   advance;
    logic [NUM_BUTTONS-1:0] pressed_next;
    logic [NUM_BUTTONS-1:0] typed_now;
    logic [NUM_BUTTONS-1:0] take_sel;
    logic                   flag;

    dba_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    genvar b;
    generate
        for (b = 0; b < NUM_BUTTONS; b++) begin : g_btn
            btn_cmd_t cmd;
            logic     level;

            assign take_sel[b] = (in_op_reg == OP_TAKE) && (32'(in_idx_reg) == b);
            assign cmd.tick    = advance && (in_op_reg == OP_TICK);
            assign cmd.take    = advance && take_sel[b];

            if (b < PIN_COUNT) begin : g_pin
                assign level = in_pins_reg[b];
            end else begin : g_nopin
                assign level = 1'b0;
            end

            dba_button u_button (
                .aclk           (aclk),
                .aresetn        (aresetn),
                .cfg            (cfg),
                .cmd            (cmd),
                .level          (level),
                .pressed_next_o (pressed_next[b]),
                .typed_o        (typed_now[b])
            );
        end
    endgenerate

    always_comb begin
        flag = 1'b0;
        for (int i = 0; i < NUM_BUTTONS; i++) begin
            flag = flag | (take_sel[i] & typed_now[i]);
        end
    end

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_tvalid && s_tready) begin
            in_valid_next = 1'b1;
        end else if (advance) begin
            in_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (advance) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_op_reg   <= op_t'(s_tuser);
            in_pins_reg <= s_tdata[PIN_COUNT-1:0];
            in_idx_reg  <= s_tdata[PIN_COUNT +: IDX_W];
        end
        if (advance) begin
            out_pressed_reg <= pressed_next[MASK_BUTTONS-1:0];
            out_typed_reg   <= flag;
        end
    end

    always_comb begin
        m_tdata                    = '0;
        m_tdata[MASK_BUTTONS-1:0]  = out_pressed_reg;
        m_tdata[PIN_COUNT]         = out_typed_reg;
    end

    assign m_tvalid = out_valid_reg;

endmodule

// ===== src/dba_cfg_regs.sv =====
// Configuration register file of the button debounce block.
// Depends on dba_pkg for the register indexes, reset values and cfg_t.
module dba_cfg_regs (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [dba_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [dba_pkg::CFG_DATA_W-1:0]   cfg_data,
    output dba_pkg::cfg_t                    cfg
);
    import dba_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            case (cfg_index)
                REG_ACTIVE_LEVEL:     cfg_next.active_level     = cfg_data[0];
                REG_DEBOUNCE_SAMPLES: cfg_next.debounce_samples = cfg_data[DEBOUNCE_W-1:0];
                REG_HOLD_DELAY:       cfg_next.hold_delay       = cfg_data[DELAY_W-1:0];
                REG_REPEAT_DELAY:     cfg_next.repeat_delay     = cfg_data[DELAY_W-1:0];
                default:              cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.active_level     <= 1'b0;
            cfg_reg.debounce_samples <= DEBOUNCE_RESET;
            cfg_reg.hold_delay       <= HOLD_RESET;
            cfg_reg.repeat_delay     <= REPEAT_RESET;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

// ===== src/dba_button.sv =====
// State and update logic of one button: debounce, hold and auto-repeat.
// Depends on dba_pkg for cfg_t, btn_cmd_t and the counter widths.
module dba_button (
    input  logic               aclk,
    input  logic               aresetn,
    input  dba_pkg::cfg_t      cfg,
    input  dba_pkg::btn_cmd_t  cmd,
    input  logic               level,
    output logic               pressed_next_o,
    output logic               typed_o
);
    import dba_pkg::*;

    logic [SAMPLE_W-1:0] sample_count_reg, sample_count_next;
    logic [DELAY_W-1:0]  delay_count_reg,  delay_count_next;
    logic                pressed_reg, pressed_next;
    logic                held_reg,    held_next;
    logic                typed_reg,   typed_next;

    logic                act;
    logic [SAMPLE_W:0]   sample_inc;
    logic                sample_hit;
    logic [DELAY_W:0]    delay_inc;
    logic                hold_hit;
    logic                repeat_hit;

    always_comb begin
        act        = (level == cfg.active_level);
        sample_inc = {1'b0, sample_count_reg} + {{SAMPLE_W{1'b0}}, 1'b1};
        sample_hit = sample_inc >= {{(SAMPLE_W + 1 - DEBOUNCE_W){1'b0}}, cfg.debounce_samples};
        delay_inc  = {1'b0, delay_count_reg} + {{DELAY_W{1'b0}}, 1'b1};
        hold_hit   = delay_inc >= {1'b0, cfg.hold_delay};
        repeat_hit = delay_inc >= {1'b0, cfg.repeat_delay};

        sample_count_next = sample_count_reg;
        delay_count_next  = delay_count_reg;
        pressed_next      = pressed_reg;
        held_next         = held_reg;
        typed_next        = typed_reg;

        if (cmd.tick) begin
            if (act) begin
                if (!pressed_reg) begin
                    if (sample_hit) begin
                        sample_count_next = '0;
                        pressed_next      = 1'b1;
                        typed_next        = 1'b1;
                    end else begin
                        sample_count_next = sample_inc[SAMPLE_W-1:0];
                    end
                end else begin
                    sample_count_next = '0;
                    if (held_reg) begin
                        if (repeat_hit) begin
                            delay_count_next = '0;
                            typed_next       = 1'b1;
                        end else begin
                            delay_count_next = delay_inc[DELAY_W-1:0];
                        end
                    end else begin
                        if (hold_hit) begin
                            delay_count_next = '0;
                            held_next        = 1'b1;
                        end else begin
                            delay_count_next = delay_inc[DELAY_W-1:0];
                        end
                    end
                end
            end else begin
                if (pressed_reg) begin
                    if (sample_hit) begin
                        sample_count_next = '0;
                        pressed_next      = 1'b0;
                        held_next         = 1'b0;
                        delay_count_next  = '0;
                        typed_next        = 1'b0;
                    end else begin
                        sample_count_next = sample_inc[SAMPLE_W-1:0];
                    end
                end else begin
                    sample_count_next = '0;
                end
            end
        end else if (cmd.take) begin
            typed_next = 1'b0;
        end
    end

    assign pressed_next_o = pressed_next;
    assign typed_o        = typed_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sample_count_reg <= '0;
            delay_count_reg  <= '0;
            pressed_reg      <= 1'b0;
            held_reg         <= 1'b0;
            typed_reg        <= 1'b0;
        end else begin
            sample_count_reg <= sample_count_next;
            delay_count_reg  <= delay_count_next;
            pressed_reg      <= pressed_next;
            held_reg         <= held_next;
            typed_reg        <= typed_next;
        end
    end

endmodule
